// ===== rtl/iar_pkg.sv =====
// Shared types, register codes and a helper function for the interface adapter register block.
package iar_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int ITEM_W     = 38;
    localparam int RESULT_W   = 19;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TIMER = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [3:0] REG_ORB  = 4'h0;
    localparam logic [3:0] REG_ORA  = 4'h1;
    localparam logic [3:0] REG_DDRB = 4'h2;
    localparam logic [3:0] REG_DDRA = 4'h3;
    localparam logic [3:0] REG_T1CL = 4'h4;
    localparam logic [3:0] REG_T1CH = 4'h5;
    localparam logic [3:0] REG_T1LL = 4'h6;
    localparam logic [3:0] REG_T1LH = 4'h7;
    localparam logic [3:0] REG_PCR  = 4'hC;
    localparam logic [3:0] REG_IFR  = 4'hD;
    localparam logic [3:0] REG_IER  = 4'hE;
    localparam logic [3:0] REG_ORA2 = 4'hF;

    localparam logic [7:0] DECODE_PAGE = 8'h03;
    localparam logic [7:0] PORTB_IDLE  = 8'hB0;
    localparam logic [7:0] FLAG_MASK   = 8'h7F;
    localparam logic [7:0] KEY_HIT     = 8'h08;
    localparam logic [7:0] T1_FLAG     = 8'h40;
    localparam logic [7:0] ANY_FLAG    = 8'h80;
    localparam logic [7:0] MOD_COLUMN  = 8'h10;
    localparam logic [3:0] PSG_KEY_REG = 4'd14;
    localparam logic [2:0] SHIFT_ROW   = 3'd4;
    localparam logic [2:0] CTRL_ROW    = 3'd2;

    // The first field sits in the highest bits.
    typedef struct packed {
        logic       ctrl_held;
        logic       key_needs_shift;
        logic [7:0] key_columns;
        logic [2:0] key_row;
        logic       key_pressed;
        logic [7:0] write_data;
        logic [15:0] address;
    } t_item;

    typedef struct packed {
        logic [7:0] psg_byte;
        logic       psg_data_strobe;
        logic       psg_index_strobe;
        logic       irq_pulse;
        logic [7:0] read_data;
    } t_result;

    // Clears the masked flags and recomputes the summary bit.
    function automatic logic [7:0] flags_clear(input logic [7:0] flags,
                                               input logic [7:0] mask,
                                               input logic [6:0] enables);
        logic [7:0] f;
        f = flags & ~mask & FLAG_MASK;
        if (|(f[6:0] & enables)) begin
            f = f | ANY_FLAG;
        end
        return f;
    endfunction

endpackage

// ===== rtl/iar_core.sv =====
// Register state and single-pass access decode of the interface adapter.
module iar_core
    import iar_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_cmd    i_cmd,
    input  t_item   i_item,
    output t_result o_result
);

    logic [7:0]  r_ora, r_orb, r_ddra, r_ddrb, r_pcr, r_flags, r_cols;
    logic [6:0]  r_en;
    logic [15:0] r_latch, r_count;
    logic [3:0]  r_psg;
    logic [2:0]  r_row;
    logic        r_motor;

    logic [7:0]  n_ora, n_orb, n_ddra, n_ddrb, n_pcr, n_flags, n_cols;
    logic [6:0]  n_en;
    logic [15:0] n_latch, n_count;
    logic [3:0]  n_psg;
    logic [2:0]  n_row;
    logic        n_motor;

    t_result     res;
    logic        page_hit;
    logic [3:0]  sel;
    logic [7:0]  wd;
    logic        key_hit;
    logic [7:0]  portb_in;
    logic [6:0]  en_new;
    logic [7:0]  t1_set;

    always_comb begin
        n_ora   = r_ora;
        n_orb   = r_orb;
        n_ddra  = r_ddra;
        n_ddrb  = r_ddrb;
        n_pcr   = r_pcr;
        n_flags = r_flags;
        n_cols  = r_cols;
        n_en    = r_en;
        n_latch = r_latch;
        n_count = r_count;
        n_psg   = r_psg;
        n_row   = r_row;
        n_motor = r_motor;
        res     = '0;

        page_hit = (i_item.address[15:8] == DECODE_PAGE);
        sel      = i_item.address[3:0];
        wd       = i_item.write_data;

        key_hit = i_item.key_pressed &&
                  (((r_row == i_item.key_row) && (|(r_cols & i_item.key_columns))) ||
                   (i_item.key_needs_shift && (r_row == SHIFT_ROW) &&
                    (|(r_cols & MOD_COLUMN))) ||
                   (i_item.ctrl_held && (r_row == CTRL_ROW) && (|(r_cols & MOD_COLUMN))));
        portb_in = PORTB_IDLE | {1'b0, r_motor, 6'b0} | {5'b0, r_row} |
                   (key_hit ? KEY_HIT : 8'h00);
        en_new   = wd[7] ? (r_en | wd[6:0]) : (r_en & ~wd[6:0]);
        t1_set   = r_flags | T1_FLAG;

        if (i_step && page_hit) begin
            unique case (i_cmd)
                CMD_READ: begin
                    case (sel)
                        REG_ORB:  res.read_data = (r_orb & r_ddrb) | (portb_in & ~r_ddrb);
                        REG_ORA, REG_ORA2: res.read_data = (r_ora & r_ddra) | ~r_ddra;
                        REG_DDRB: res.read_data = r_ddrb;
                        REG_DDRA: res.read_data = r_ddra;
                        REG_T1CL: begin
                            res.read_data = r_count[7:0];
                            n_flags       = flags_clear(r_flags, T1_FLAG, r_en);
                        end
                        REG_T1CH: res.read_data = r_count[15:8];
                        REG_T1LL: res.read_data = r_latch[7:0];
                        REG_T1LH: res.read_data = r_latch[15:8];
                        REG_PCR:  res.read_data = r_pcr;
                        REG_IFR:  res.read_data = r_flags;
                        REG_IER:  res.read_data = {1'b1, r_en};
                        default:  res.read_data = 8'h00;
                    endcase
                end
                CMD_WRITE: begin
                    case (sel)
                        REG_ORB: begin
                            n_row   = wd[2:0];
                            n_motor = wd[6];
                            n_orb   = wd;
                        end
                        REG_ORA, REG_ORA2: n_ora = wd;
                        REG_DDRB: n_ddrb = wd;
                        REG_DDRA: n_ddra = wd;
                        REG_T1CL, REG_T1LL: n_latch = {r_latch[15:8], wd};
                        REG_T1CH: begin
                            n_latch = {wd, r_latch[7:0]};
                            n_count = {wd, r_latch[7:0]};
                            n_flags = flags_clear(r_flags, T1_FLAG, r_en);
                        end
                        REG_T1LH: begin
                            n_latch = {wd, r_latch[7:0]};
                            n_flags = flags_clear(r_flags, T1_FLAG, r_en);
                        end
                        REG_PCR: begin
                            n_pcr = wd;
                            if (wd[2]) begin
                                res.psg_byte = r_ora;
                                if (wd[1]) begin
                                    res.psg_index_strobe = 1'b1;
                                    n_psg = r_ora[3:0];
                                end else begin
                                    res.psg_data_strobe = 1'b1;
                                    if (r_psg == PSG_KEY_REG) begin
                                        n_cols = ~r_ora;
                                    end
                                end
                            end
                        end
                        REG_IFR: n_flags = flags_clear(r_flags,
                                                       wd[7] ? FLAG_MASK : wd, r_en);
                        REG_IER: begin
                            n_en = en_new;
                            if (r_flags[7]) begin
                                if (!(|(r_flags[6:0] & en_new))) begin
                                    n_flags = r_flags & FLAG_MASK;
                                end
                            end else if (|(r_flags[6:0] & en_new)) begin
                                n_flags       = r_flags | ANY_FLAG;
                                res.irq_pulse = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        if (i_step && (i_cmd == CMD_TIMER)) begin
            n_flags = (|(t1_set[6:0] & r_en)) ? (t1_set | ANY_FLAG) : t1_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ora   <= '0;
            r_orb   <= '0;
            r_ddra  <= '0;
            r_ddrb  <= '0;
            r_pcr   <= '0;
            r_flags <= '0;
            r_cols  <= '0;
            r_en    <= '0;
            r_latch <= '0;
            r_count <= '0;
            r_psg   <= '0;
            r_row   <= '0;
            r_motor <= 1'b0;
        end else begin
            r_ora   <= n_ora;
            r_orb   <= n_orb;
            r_ddra  <= n_ddra;
            r_ddrb  <= n_ddrb;
            r_pcr   <= n_pcr;
            r_flags <= n_flags;
            r_cols  <= n_cols;
            r_en    <= n_en;
            r_latch <= n_latch;
            r_count <= n_count;
            r_psg   <= n_psg;
            r_row   <= n_row;
            r_motor <= n_motor;
        end
    end

    assign o_result = res;

    a_any_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags[7] == (|(r_flags[6:0] & r_en)))
        else $error("Summary interrupt flag disagrees with pending enabled flags.");

    a_strobe_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res.psg_index_strobe && res.psg_data_strobe))
        else $error("Both sound chip strobes are active.");

    a_psg_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res.psg_index_strobe || res.psg_data_strobe) |-> (res.psg_byte == 8'h00))
        else $error("Sound chip byte is driven without a strobe.");

    a_irq_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.irq_pulse) |=> r_flags[7])
        else $error("Interrupt pulse without a pending interrupt afterwards.");

endmodule

// ===== rtl/interface_adapter_registers_top.sv =====
// Top level of the interface adapter register block with stream handshakes.
// Throughput: one item per cycle unless i_m_tready stalls the output; an input
// register and an output register hold one item each, and all register work
// happens in one pass between them.
// Reset: i_rst_n is synchronous and active low; it empties both stages and
// clears every adapter register to zero.
module interface_adapter_registers_top
    import iar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // address, write_data, key_pressed, key_row, key_columns, key_needs_shift, ctrl_held
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // cmd
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // read_data, irq_pulse, psg_index_strobe, psg_data_strobe, psg_byte
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic    r_in_valid;
    t_cmd    r_in_cmd;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    logic    step;
    t_result result;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign step       = r_in_valid && advance;

    iar_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cmd    (r_in_cmd),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd  <= t_cmd'(i_s_tuser);
            r_in_item <= t_item'(i_s_tdata[ITEM_W-1:0]);
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-RESULT_W){1'b0}}, r_out};

endmodule

// ===== tb/tb_interface_adapter_registers_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench that predicts and checks every result of the interface adapter block.
module tb_interface_adapter_registers_top;
    import iar_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int PRINT_LIMIT     = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [IN_USER_W-1:0]  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    interface_adapter_registers_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    logic [7:0]  port_a_q;
    logic [7:0]  port_b_q;
    logic [7:0]  dir_a_q;
    logic [7:0]  dir_b_q;
    logic [7:0]  pcr_q;
    logic [7:0]  flags_q;
    logic [6:0]  enables_q;
    logic [15:0] latch_q;
    logic [15:0] count_q;
    logic [3:0]  psg_sel_q;
    logic [2:0]  row_q;
    logic [7:0]  cols_q;
    logic        motor_q;

    t_result pending_results[$];
    int      mismatches;
    int      items_sent;
    int      idle_cycles;
    bit      tx_gaps_on;
    bit      rx_stalls_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] flags_after_clear(input logic [7:0] mask);
        logic [7:0] f;
        f = flags_q & ~mask & FLAG_MASK;
        if ((f[6:0] & enables_q) != 0) begin
            f[7] = 1'b1;
        end
        return f;
    endfunction

    function automatic t_result predict_bus_access(input t_cmd cmd, input t_item it);
        t_result    r;
        logic [3:0] sel;
        logic [7:0] b;
        logic [7:0] v;
        logic       hit;
        logic       decoded;
        r       = '0;
        sel     = it.address[3:0];
        b       = it.write_data;
        decoded = (it.address[15:8] == DECODE_PAGE);
        case (cmd)
            CMD_READ: begin
                if (decoded) begin
                    case (sel)
                        REG_ORB: begin
                            hit = it.key_pressed &&
                                ((it.key_row == row_q && (cols_q & it.key_columns) != 0) ||
                                 (it.key_needs_shift && row_q == SHIFT_ROW &&
                                  (cols_q & MOD_COLUMN) != 0) ||
                                 (it.ctrl_held && row_q == CTRL_ROW &&
                                  (cols_q & MOD_COLUMN) != 0));
                            v = PORTB_IDLE | {1'b0, motor_q, 2'b00, hit, row_q};
                            r.read_data = (port_b_q & dir_b_q) | (v & ~dir_b_q);
                        end
                        REG_ORA, REG_ORA2: r.read_data = (port_a_q & dir_a_q) | ~dir_a_q;
                        REG_DDRB: r.read_data = dir_b_q;
                        REG_DDRA: r.read_data = dir_a_q;
                        REG_T1CL: begin
                            r.read_data = count_q[7:0];
                            flags_q     = flags_after_clear(T1_FLAG);
                        end
                        REG_T1CH: r.read_data = count_q[15:8];
                        REG_T1LL: r.read_data = latch_q[7:0];
                        REG_T1LH: r.read_data = latch_q[15:8];
                        REG_PCR:  r.read_data = pcr_q;
                        REG_IFR:  r.read_data = flags_q;
                        REG_IER:  r.read_data = {1'b1, enables_q};
                        default:  r.read_data = '0;
                    endcase
                end
            end
            CMD_WRITE: begin
                if (decoded) begin
                    case (sel)
                        REG_ORB: begin
                            row_q    = b[2:0];
                            motor_q  = b[6];
                            port_b_q = b;
                        end
                        REG_ORA, REG_ORA2: port_a_q = b;
                        REG_DDRB: dir_b_q = b;
                        REG_DDRA: dir_a_q = b;
                        REG_T1CL, REG_T1LL: latch_q[7:0] = b;
                        REG_T1CH: begin
                            latch_q[15:8] = b;
                            count_q       = latch_q;
                            flags_q       = flags_after_clear(T1_FLAG);
                        end
                        REG_T1LH: begin
                            latch_q[15:8] = b;
                            flags_q       = flags_after_clear(T1_FLAG);
                        end
                        REG_PCR: begin
                            pcr_q = b;
                            if (b[2]) begin
                                r.psg_byte = port_a_q;
                                if (b[1]) begin
                                    r.psg_index_strobe = 1'b1;
                                    psg_sel_q          = port_a_q[3:0];
                                end else begin
                                    r.psg_data_strobe = 1'b1;
                                    if (psg_sel_q == PSG_KEY_REG) begin
                                        cols_q = ~port_a_q;
                                    end
                                end
                            end
                        end
                        REG_IFR: flags_q = flags_after_clear(b[7] ? FLAG_MASK : b);
                        REG_IER: begin
                            enables_q = b[7] ? (enables_q | b[6:0]) : (enables_q & ~b[6:0]);
                            if (flags_q[7]) begin
                                if ((flags_q[6:0] & enables_q) == 0) begin
                                    flags_q[7] = 1'b0;
                                end
                            end else if ((flags_q[6:0] & enables_q) != 0) begin
                                flags_q[7]  = 1'b1;
                                r.irq_pulse = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_TIMER: begin
                flags_q = flags_q | T1_FLAG;
                if ((flags_q[6:0] & enables_q) != 0) begin
                    flags_q[7] = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Caller is at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input t_cmd cmd, input t_item it);
        int unsigned gap;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        repeat (gap) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_DATA_W - ITEM_W){1'b0}}, it};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(predict_bus_access(cmd, it));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    function automatic t_item bus_item(input logic [3:0] sel, input logic [7:0] data);
        t_item       it;
        logic [63:0] raw;
        raw                = {$urandom, $urandom};
        it                 = raw[ITEM_W-1:0];
        it.address[15:8]   = DECODE_PAGE;
        it.address[3:0]    = sel;
        it.write_data      = data;
        return it;
    endfunction

    task automatic test_reset_state();
        t_item it;
        it             = bus_item(REG_ORB, 8'h00);
        it.key_pressed = 1'b1;
        it.key_columns = 8'hFF;
        send_item(CMD_READ, it);
        send_item(CMD_READ, bus_item(REG_IER, 8'h00));
    endtask

    task automatic test_port_registers();
        t_item it;
        send_item(CMD_WRITE, bus_item(REG_DDRA, 8'hF0));
        it              = bus_item(REG_ORA2, 8'hA5);
        it.address[7:4] = 4'hF;
        send_item(CMD_WRITE, it);
        send_item(CMD_READ, bus_item(REG_ORA, 8'hFF));
        send_item(CMD_WRITE, bus_item(REG_ORB, 8'hC4));
        send_item(CMD_WRITE, bus_item(REG_DDRB, 8'hC0));
        send_item(CMD_READ, bus_item(REG_ORB, 8'h00));
    endtask

    task automatic test_timer_interrupts();
        send_item(CMD_WRITE, bus_item(REG_T1LL, 8'h34));
        send_item(CMD_WRITE, bus_item(REG_T1CH, 8'h12));
        send_item(CMD_TIMER, bus_item(REG_ORB, 8'h00));
        send_item(CMD_WRITE, bus_item(REG_IER, 8'hC0));
        send_item(CMD_READ, bus_item(REG_IFR, 8'h00));
        send_item(CMD_READ, bus_item(REG_T1CL, 8'h00));
        send_item(CMD_READ, bus_item(REG_IFR, 8'h00));
    endtask

    task automatic test_sound_chip_strobes();
        send_item(CMD_WRITE, bus_item(REG_ORA, {4'h0, PSG_KEY_REG}));
        send_item(CMD_WRITE, bus_item(REG_PCR, 8'h06));
        send_item(CMD_WRITE, bus_item(REG_ORA, 8'hEF));
        send_item(CMD_WRITE, bus_item(REG_PCR, 8'h04));
        send_item(CMD_READ, bus_item(REG_PCR, 8'h00));
    endtask

    task automatic test_keyboard_matrix();
        t_item it;
        send_item(CMD_WRITE, bus_item(REG_ORB, {5'b00000, SHIFT_ROW}));
        it                 = bus_item(REG_ORB, 8'h00);
        it.key_pressed     = 1'b1;
        it.key_row         = 3'd0;
        it.key_columns     = 8'h00;
        it.key_needs_shift = 1'b1;
        it.ctrl_held       = 1'b0;
        send_item(CMD_READ, it);
        it.key_row         = SHIFT_ROW;
        it.key_columns     = 8'hFF;
        it.key_needs_shift = 1'b0;
        it.ctrl_held       = 1'b1;
        send_item(CMD_READ, it);
        send_item(CMD_WRITE, bus_item(REG_ORB, {5'b00000, CTRL_ROW}));
        it.key_row         = 3'd7;
        it.key_columns     = 8'h00;
        send_item(CMD_READ, it);
        it.key_pressed     = 1'b0;
        it.key_row         = CTRL_ROW;
        it.key_columns     = 8'hFF;
        it.key_needs_shift = 1'b1;
        send_item(CMD_READ, it);
    endtask

    task automatic test_unmapped_access();
        t_item it;
        it         = bus_item(REG_ORB, 8'hFF);
        it.address = 16'hFFFF;
        send_item(CMD_READ, it);
        it.address = 16'h0000;
        send_item(CMD_WRITE, it);
        send_item(CMD_WRITE, bus_item(4'hA, 8'hFF));
        send_item(CMD_NONE, bus_item(REG_ORB, 8'hFF));
    endtask

    task automatic keyboard_scan_sequence();
        t_item      it;
        logic [7:0] rnd;
        logic [2:0] row;
        rnd = $urandom;
        row = $urandom_range(0, 7);
        send_item(CMD_WRITE, bus_item(REG_ORA, {rnd[7:4], PSG_KEY_REG}));
        send_item(CMD_WRITE, bus_item(REG_PCR, {rnd[7:3], 2'b11, rnd[0]}));
        send_item(CMD_WRITE, bus_item(REG_ORA, 8'($urandom)));
        rnd = $urandom;
        send_item(CMD_WRITE, bus_item(REG_PCR, {rnd[7:3], 2'b10, rnd[0]}));
        if ($urandom_range(0, 2) == 0) begin
            send_item(CMD_WRITE,
                      bus_item(REG_DDRB, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00));
        end
        send_item(CMD_WRITE, bus_item(REG_ORB, {rnd[7:3], row}));
        repeat ($urandom_range(1, 4)) begin
            it             = bus_item(REG_ORB, 8'($urandom));
            it.key_pressed = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 1) == 0) begin
                it.key_row = row;
            end
            send_item(CMD_READ, it);
        end
    endtask

    task automatic random_register_access();
        t_item       it;
        t_cmd        cmd;
        logic [63:0] raw;
        int unsigned w;
        if ($urandom_range(0, 99) < 85) begin
            it = bus_item(4'($urandom_range(0, 15)), 8'($urandom));
            w  = $urandom_range(0, 99);
            cmd = (w < 45) ? CMD_READ : (w < 90) ? CMD_WRITE : (w < 97) ? CMD_TIMER : CMD_NONE;
        end else begin
            raw = {$urandom, $urandom};
            it  = raw[ITEM_W-1:0];
            cmd = t_cmd'(raw[63:62]);
        end
        send_item(cmd, it);
    endtask

    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            tx_gaps_on   = (phase == 0 || phase == 2);
            rx_stalls_on = (phase == 0 || phase == 3);
            target       = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(0, 3) == 0) begin
                    keyboard_scan_sequence();
                end else begin
                    random_register_access();
                end
            end
            if (phase == 1) begin
                drain_results();
            end
        end
    endtask

    initial begin
        int unsigned stall;
        i_m_tready = 1'b0;
        stall      = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else begin
                i_m_tready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
                    stall = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[RESULT_W-1:0];
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", got));
            end else begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data) begin
                    report_mismatch($sformatf("read_data %h, expected %h",
                                              got.read_data, want.read_data));
                end
                if (got.irq_pulse !== want.irq_pulse) begin
                    report_mismatch($sformatf("irq_pulse %b, expected %b",
                                              got.irq_pulse, want.irq_pulse));
                end
                if (got.psg_index_strobe !== want.psg_index_strobe) begin
                    report_mismatch($sformatf("psg_index_strobe %b, expected %b",
                                              got.psg_index_strobe, want.psg_index_strobe));
                end
                if (got.psg_data_strobe !== want.psg_data_strobe) begin
                    report_mismatch($sformatf("psg_data_strobe %b, expected %b",
                                              got.psg_data_strobe, want.psg_data_strobe));
                end
                if (got.psg_byte !== want.psg_byte) begin
                    report_mismatch($sformatf("psg_byte %h, expected %h",
                                              got.psg_byte, want.psg_byte));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        port_a_q     = '0;
        port_b_q     = '0;
        dir_a_q      = '0;
        dir_b_q      = '0;
        pcr_q        = '0;
        flags_q      = '0;
        enables_q    = '0;
        latch_q      = '0;
        count_q      = '0;
        psg_sel_q    = '0;
        row_q        = '0;
        cols_q       = '0;
        motor_q      = 1'b0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_port_registers();
        test_timer_interrupts();
        test_sound_chip_strobes();
        test_keyboard_matrix();
        test_unmapped_access();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/iar_pkg.sv
rtl/iar_core.sv
rtl/interface_adapter_registers_top.sv
tb/tb_interface_adapter_registers_top.sv
